// ===== rtl/qrt_pkg.sv =====
`timescale 1ns / 1ps
package qrt_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int REPLICA_COUNT = 3;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int ID_W = 31;
  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam int TO_W = 16;

  typedef enum logic [1:0] {
    CMD_ISSUE = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_SUCCESS  = 2'd0,
    ST_FAILURE  = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_QUORUM  = 2'd0,
    REG_REPLY   = 2'd1,
    REG_REMOVE  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  quorum;
    logic [TO_W-1:0] reply_to;
    logic [TO_W-1:0] remove_to;
  } cfg_t;
endpackage

// ===== rtl/qrt_cfg.sv =====
`timescale 1ns / 1ps
module qrt_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output qrt_pkg::cfg_t cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quorum <= 2'd2;
      cfg.reply_to <= 16'd10;
      cfg.remove_to <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qrt_pkg::REG_QUORUM: cfg.quorum <= cfg_data[1:0];
        qrt_pkg::REG_REPLY:  cfg.reply_to <= cfg_data;
        qrt_pkg::REG_REMOVE: cfg.remove_to <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/quorum_reply_tracker.sv =====
`timescale 1ns / 1ps
// Pending transaction table of 16 slots, each slot examined in turn by one shared
// compare/evaluate datapath. An issue, reply or tick item is taken when start is
// high and busy is low. A full table walk keeps busy high through a read and an
// evaluate state per slot plus a closing state, and no new item is taken until
// it is over; a reply or duplicate issue stops at the slot holding its id, and an
// unused command stops after the first slot. Results come out as single-cycle
// strobes on result_valid and cannot be held off; last_of_run marks the final
// result beat of an item.
module quorum_reply_tracker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0] cmd,
  input  logic [30:0] trans_id,
  input  logic [1:0] op_type,
  input  logic [47:0] replica_addr_a,
  input  logic [47:0] replica_addr_b,
  input  logic [47:0] replica_addr_c,
  input  logic [47:0] from_addr,
  input  logic reply_is_read,
  input  logic reply_success,
  input  logic value_present,
  input  logic [31:0] now_time,
  output logic result_valid,
  output logic [1:0] status,
  output logic [30:0] out_trans_id,
  output logic [1:0] out_op_type,
  output logic last_of_run
);
  localparam int SW = qrt_pkg::SLOT_W;
  localparam int D = qrt_pkg::TABLE_DEPTH;
  localparam int R = qrt_pkg::REPLICA_COUNT;

  qrt_pkg::cfg_t cfg;
  qrt_cfg u_cfg (.clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
                 .cfg_data(cfg_data), .cfg(cfg));

  // slot memory
  logic [D-1:0] valid;
  logic [30:0] mem_id [D];
  logic [1:0]  mem_op [D];
  logic [31:0] mem_time [D];
  logic [47:0] mem_addr [D][R];
  logic [R-1:0] mem_rep [D];
  logic [R-1:0] mem_suc [D];

  qrt_pkg::state_t state, state_next;
  logic [1:0] c_cmd;
  logic [30:0] c_id;
  logic [1:0] c_op;
  logic [47:0] c_a [R];
  logic [47:0] c_from;
  logic c_ok;
  logic [31:0] c_now;
  logic [SW:0] idx;
  logic [SW-1:0] slot;
  logic found, have_free;
  logic [SW-1:0] free_slot;

  // registered read of the current slot
  logic r_valid;
  logic [30:0] r_id;
  logic [1:0] r_op;
  logic [31:0] r_time;
  logic [47:0] r_addr [R];
  logic [R-1:0] r_rep, r_suc;

  // pending result held back so last_of_run can be set on the final one
  logic pend;
  logic [1:0] p_status;
  logic [30:0] p_id;
  logic [1:0] p_op;

  assign slot = idx[SW-1:0];
  assign busy = (state != qrt_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    r_id <= mem_id[slot];
    r_op <= mem_op[slot];
    r_time <= mem_time[slot];
    for (int t = 0; t < R; t++) r_addr[t] <= mem_addr[slot][t];
    r_rep <= mem_rep[slot];
    r_suc <= mem_suc[slot];
    r_valid <= valid[slot];
  end

  // evaluation of the registered slot
  logic [31:0] age;
  logic drop, timed;
  logic [1:0] succ, bad;
  logic id_hit;
  logic [R-1:0] amatch;
  assign age = c_now - r_time;
  assign drop = age > {16'd0, cfg.remove_to};
  assign timed = age > {16'd0, cfg.reply_to};
  assign id_hit = r_valid && (r_id == c_id);
  always_comb begin
    succ = '0;
    bad = '0;
    for (int t = 0; t < R; t++) begin
      amatch[t] = (r_addr[t] == c_from);
      if (r_rep[t]) begin
        if (r_suc[t]) succ = succ + 2'd1;
        else bad = bad + 2'd1;
      end else if (timed) begin
        bad = bad + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qrt_pkg::S_IDLE:   if (start) state_next = qrt_pkg::S_RD;
      qrt_pkg::S_RD:     state_next = qrt_pkg::S_EVAL;
      qrt_pkg::S_EVAL:   begin
        if (idx == (SW+1)'(D-1) ||
            (c_cmd == qrt_pkg::CMD_REPLY && id_hit) ||
            (c_cmd == qrt_pkg::CMD_ISSUE && id_hit) ||
            c_cmd == qrt_pkg::CMD_NONE)
          state_next = qrt_pkg::S_DONE;
        else
          state_next = qrt_pkg::S_RD;
      end
      qrt_pkg::S_DONE:   state_next = qrt_pkg::S_IDLE;
      default:           state_next = qrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= qrt_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      pend <= 1'b0;
      result_valid <= 1'b0;
      found <= 1'b0;
      have_free <= 1'b0;
      idx <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        qrt_pkg::S_IDLE: begin
          if (start) begin
            c_cmd <= cmd; c_id <= trans_id; c_op <= op_type;
            c_a[0] <= replica_addr_a; c_a[1] <= replica_addr_b;
            c_a[2] <= replica_addr_c;
            c_from <= from_addr; c_now <= now_time;
            c_ok <= reply_is_read ? value_present : reply_success;
            idx <= '0; found <= 1'b0; have_free <= 1'b0; pend <= 1'b0;
          end
        end
        qrt_pkg::S_RD: ;
        qrt_pkg::S_EVAL: begin
          idx <= idx + (SW+1)'(1);
          unique case (c_cmd)
            qrt_pkg::CMD_ISSUE: begin
              if (id_hit) found <= 1'b1;
              if (!r_valid && !have_free) begin
                have_free <= 1'b1; free_slot <= slot;
              end
            end
            qrt_pkg::CMD_REPLY: begin
              if (id_hit) begin
                found <= 1'b1;
                priority if (amatch[0]) begin
                  mem_rep[slot][0] <= 1'b1; mem_suc[slot][0] <= c_ok;
                end else if (amatch[1]) begin
                  mem_rep[slot][1] <= 1'b1; mem_suc[slot][1] <= c_ok;
                end else if (amatch[2]) begin
                  mem_rep[slot][2] <= 1'b1; mem_suc[slot][2] <= c_ok;
                end
              end
            end
            qrt_pkg::CMD_TICK: begin
              if (r_valid) begin
                if (drop) valid[slot] <= 1'b0;
                else if (succ >= cfg.quorum || bad >= cfg.quorum) begin
                  valid[slot] <= 1'b0;
                  if (pend) begin
                    result_valid <= 1'b1; last_of_run <= 1'b0;
                    status <= p_status; out_trans_id <= p_id; out_op_type <= p_op;
                  end
                  pend <= 1'b1;
                  p_status <= (succ >= cfg.quorum) ? qrt_pkg::ST_SUCCESS
                                                   : qrt_pkg::ST_FAILURE;
                  p_id <= r_id; p_op <= r_op;
                end
              end
            end
            default: ;
          endcase
        end
        qrt_pkg::S_DONE: begin
          if (c_cmd == qrt_pkg::CMD_TICK && pend) begin
            result_valid <= 1'b1; last_of_run <= 1'b1;
            status <= p_status; out_trans_id <= p_id; out_op_type <= p_op;
          end
          if (c_cmd == qrt_pkg::CMD_ISSUE && !found) begin
            if (have_free) begin
              valid[free_slot] <= 1'b1;
              mem_id[free_slot] <= c_id; mem_op[free_slot] <= c_op;
              mem_time[free_slot] <= c_now;
              for (int t = 0; t < R; t++) mem_addr[free_slot][t] <= c_a[t];
              mem_rep[free_slot] <= '0; mem_suc[free_slot] <= '0;
            end else begin
              result_valid <= 1'b1; last_of_run <= 1'b1;
              status <= qrt_pkg::ST_REJECTED; out_trans_id <= c_id; out_op_type <= c_op;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/qrt_checker.sv =====
`timescale 1ns / 1ps
module qrt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input logic [1:0] status,
  input logic last_of_run
);
  a_no_res_idle_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid) else $error("result right after accept");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= qrt_pkg::ST_REJECTED)) else $error("bad status");
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == qrt_pkg::ST_REJECTED) |-> last_of_run)
    else $error("reject not last");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after accept");
endmodule

bind quorum_reply_tracker qrt_checker u_qrt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid),
  .status(status), .last_of_run(last_of_run));
